/* hdl/vct_pkg.sv */
// Shared types and constants for the verdict cache table.
// No dependencies; used by vct_hash and verdict_cache_table_unit.
`timescale 1ns / 1ps
package vct_pkg;

  localparam int unsigned SET_BITS_DEF     = 9;
  localparam int unsigned WAYS_DEF         = 4;
  localparam int unsigned MODULE_COUNT_DEF = 4;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned VERDICT_W = 4;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned MOD_W     = 4;

  localparam logic [63:0] HASH_MULT = 64'h61C8_8646_80B5_83EB;
  localparam logic [31:0] AGE_RESET = 32'd180000;

  localparam logic [VERDICT_W-1:0] VERDICT_PENDING = 4'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FAIL    = 4'd1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CHECK  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVAL    = 2'd1,
    STATUS_NOROOM   = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

/* hdl/vct_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/vct_hash.sv */
// Multiplicative set hash: top bits of key * golden-ratio constant (mod 2^64).
// One shared 32x32 multiplier computes three partial products in turn, and done_o marks the set as ready;
// depends on vct_pkg.
`timescale 1ns / 1ps
module vct_hash #(
  parameter int unsigned SET_BITS = vct_pkg::SET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vct_pkg::KEY_W-1:0]     key_i,
  output logic                          done_o,
  output logic [SET_BITS-1:0]           set_o
);
  import vct_pkg::*;

  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] op_a, op_b, hash_hi;

  // upper word of key*M mod 2^64: hi(kl*ml) + lo(kh*ml) + lo(kl*mh)
  always_comb begin
    unique case (cnt_q)
      2'd0:    begin op_a = key_i[31:0];  op_b = HASH_MULT[31:0];  end
      2'd1:    begin op_a = key_i[63:32]; op_b = HASH_MULT[31:0];  end
      default: begin op_a = key_i[31:0];  op_b = HASH_MULT[63:32]; end
    endcase
    prod_d = op_a * op_b;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
    end else if (busy_q) begin
      unique case (cnt_q)
        2'd0:    acc_d = acc_q;
        2'd1:    acc_d = prod_q[63:32];
        2'd2:    acc_d = acc_q + prod_q[31:0];
        default: busy_d = 1'b0;
      endcase
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  assign hash_hi = acc_q + prod_q[31:0];
  assign done_o  = busy_q && (cnt_q == 2'd3);
  assign set_o   = hash_hi[31 -: SET_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (busy_q && cnt_q != 2'd3) begin
      prod_q <= prod_d;
    end
  end

endmodule

/* hdl/verdict_cache_table_unit.sv */
// Verdict cache table top level: one set row per memory word, read-modify-write.
// Depends on vct_pkg, vct_ram and vct_hash.
// Add/check/remove pass from accept through the hash, read, write-back and output
// states in order; one request at a time, none taken until the result leaves DONE.
// Invalid requests go straight to the output state; clear sweeps 2^SET_BITS rows.
// After reset the same sweep of all 2^SET_BITS rows runs before the first request.
`timescale 1ns / 1ps
module verdict_cache_table_unit #(
  parameter int unsigned SET_BITS     = vct_pkg::SET_BITS_DEF,
  parameter int unsigned WAYS         = vct_pkg::WAYS_DEF,
  parameter int unsigned MODULE_COUNT = vct_pkg::MODULE_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      op_i,
  input  logic [vct_pkg::KEY_W-1:0]       file_key_i,
  input  logic [vct_pkg::MOD_W-1:0]       module_index_i,
  input  logic [vct_pkg::VERDICT_W-1:0]   new_verdict_i,
  input  logic [vct_pkg::LEVEL_W-1:0]     new_level_i,
  input  logic                            writable_mount_i,
  input  logic [vct_pkg::TICK_W-1:0]      now_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [vct_pkg::VERDICT_W-1:0]   verdict_o,
  output logic [vct_pkg::LEVEL_W-1:0]     level_o
);
  import vct_pkg::*;

  localparam int unsigned SETS  = 1 << SET_BITS;
  localparam int unsigned VW    = VERDICT_W * MODULE_COUNT;
  // entry layout, msb first: valid, key, verdicts, level, writable, stamp
  localparam int unsigned O_ST  = 0;
  localparam int unsigned O_WR  = TICK_W;
  localparam int unsigned O_LV  = O_WR + 1;
  localparam int unsigned O_VD  = O_LV + LEVEL_W;
  localparam int unsigned O_KEY = O_VD + VW;
  localparam int unsigned O_VAL = O_KEY + KEY_W;
  localparam int unsigned EW    = O_VAL + 1;
  localparam int unsigned RW    = EW * WAYS;

  state_e state_q, state_d;

  logic [31:0]         age_q;
  op_e                 op_q;
  logic [KEY_W-1:0]    key_q;
  logic [MOD_W-1:0]    mod_q;
  logic [VERDICT_W-1:0] nv_q;
  logic [LEVEL_W-1:0]  nl_q;
  logic                wr_q;
  logic [TICK_W-1:0]   now_q;
  logic [SET_BITS-1:0] set_q, set_d;
  logic [SET_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                clr_emit_q, clr_emit_d;

  status_e              res_st_q, res_st_d;
  logic [VERDICT_W-1:0] res_vd_q, res_vd_d;
  logic [LEVEL_W-1:0]   res_lv_q, res_lv_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_st_q;
  logic [VERDICT_W-1:0] out_vd_q;
  logic [LEVEL_W-1:0]   out_lv_q;

  logic                accept, arg_bad, out_free, load_out;
  logic                hash_start, hash_done;
  logic [SET_BITS-1:0] hash_set;
  logic                ram_we, ram_re;
  logic [SET_BITS-1:0] ram_waddr;
  logic [RW-1:0]       ram_wdata, ram_rdata, row_new;

  // row update results
  status_e              upd_st;
  logic [VERDICT_W-1:0] upd_vd;
  logic [LEVEL_W-1:0]   upd_lv;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign arg_bad     = (file_key_i == '0) ||
                       ((op_e'(op_i) != OP_REMOVE) &&
                        ({28'd0, module_index_i} >= MODULE_COUNT));
  assign out_free    = !out_valid_q || out_ready_i;

  vct_hash #(.SET_BITS(SET_BITS)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_q),
    .done_o  (hash_done),
    .set_o   (hash_set)
  );

  vct_ram #(.WIDTH(RW), .DEPTH(SETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (hash_set),
    .rdata_o (ram_rdata)
  );

  // set update, all ways in parallel
  always_comb begin
    logic [EW-1:0]    ent;
    logic             vld, hit, found, placed;
    logic [VW-1:0]    vds;
    logic [31:0]      age_d;
    logic [WAYS-1:0]  hit_v;
    row_new = ram_rdata;
    upd_st  = STATUS_OK;
    upd_vd  = VERDICT_PENDING;
    upd_lv  = '0;
    found   = 1'b0;
    placed  = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      ent      = ram_rdata[w*EW +: EW];
      hit_v[w] = ent[O_VAL] && (ent[O_KEY +: KEY_W] == key_q);
    end
    if (op_q == OP_CHECK) begin
      upd_st = STATUS_NOTFOUND;
    end else if (op_q == OP_REMOVE) begin
      upd_st = STATUS_NOTFOUND;
    end
    for (int w = 0; w < WAYS; w++) begin
      ent = ram_rdata[w*EW +: EW];
      vld = ent[O_VAL];
      hit = hit_v[w];
      vds = ent[O_VD +: VW];
      unique case (op_q)
        OP_ADD: begin
          if (hit && !found) begin
            found = 1'b1;
            for (int m = 0; m < MODULE_COUNT; m++) begin
              if ({28'd0, mod_q} == m) vds[m*VERDICT_W +: VERDICT_W] = nv_q;
            end
            ent[O_VD +: VW] = vds;
            ent[O_WR]       = wr_q;
            if (ent[O_LV +: LEVEL_W] < nl_q) ent[O_LV +: LEVEL_W] = nl_q;
            ent[O_ST +: TICK_W] = now_q;
          end
        end
        OP_CHECK: begin
          if (hit) begin
            upd_st = STATUS_OK;
            upd_lv = ent[O_LV +: LEVEL_W];
            upd_vd = VERDICT_PENDING;
            for (int m = 0; m < MODULE_COUNT; m++) begin
              if ({28'd0, mod_q} == m) upd_vd = vds[m*VERDICT_W +: VERDICT_W];
            end
            if (ent[O_WR] != wr_q) upd_vd = VERDICT_FAIL;
            ent[O_ST +: TICK_W] = now_q;
          end else if (vld) begin
            age_d = ent[O_ST +: TICK_W] + age_q - now_q;
            if (age_d[31]) ent[O_VAL] = 1'b0;
          end
        end
        OP_REMOVE: begin
          if (hit && !found) begin
            found      = 1'b1;
            upd_st     = STATUS_OK;
            ent[O_VAL] = 1'b0;
          end
        end
        default: ;
      endcase
      row_new[w*EW +: EW] = ent;
    end
    // insertion into the first free way when no entry matched
    if (op_q == OP_ADD && hit_v == '0) begin
      for (int w = 0; w < WAYS; w++) begin
        ent = ram_rdata[w*EW +: EW];
        if (!ent[O_VAL] && !placed) begin
          placed = 1'b1;
          vds    = '0;
          for (int m = 0; m < MODULE_COUNT; m++) begin
            if ({28'd0, mod_q} == m) vds[m*VERDICT_W +: VERDICT_W] = nv_q;
          end
          ent[O_VAL]            = 1'b1;
          ent[O_KEY +: KEY_W]   = key_q;
          ent[O_VD +: VW]       = vds;
          ent[O_LV +: LEVEL_W]  = nl_q;
          ent[O_WR]             = wr_q;
          ent[O_ST +: TICK_W]   = now_q;
          row_new[w*EW +: EW]   = ent;
        end
      end
      if (!placed) upd_st = STATUS_NOROOM;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == SET_BITS'(SETS - 1)) begin
          state_d = clr_emit_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_e'(op_i) == OP_CLEAR) state_d = ST_CLEAR;
          else if (arg_bad)            state_d = ST_DONE;
          else                         state_d = ST_HASH;
        end
      end
      ST_HASH:  if (hash_done) state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    hash_start  = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = row_new;
    set_d       = set_q;
    clr_cnt_d   = clr_cnt_q;
    clr_emit_d  = clr_emit_q;
    res_st_d    = res_st_q;
    res_vd_d    = res_vd_q;
    res_lv_d    = res_lv_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          res_st_d   = arg_bad ? STATUS_INVAL : STATUS_OK;
          res_vd_d   = VERDICT_PENDING;
          res_lv_d   = '0;
          clr_cnt_d  = '0;
          clr_emit_d = 1'b1;
          hash_start = (op_e'(op_i) != OP_CLEAR) && !arg_bad;
          if (op_e'(op_i) == OP_CLEAR) res_st_d = STATUS_OK;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          ram_re = 1'b1;
          set_d  = hash_set;
        end
      end
      ST_READ: ;
      ST_WRITE: begin
        ram_we   = 1'b1;
        res_st_d = upd_st;
        res_vd_d = upd_vd;
        res_lv_d = upd_lv;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
      age_q       <= AGE_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_emit_q  <= clr_emit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) age_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      key_q <= file_key_i;
      mod_q <= module_index_i;
      nv_q  <= new_verdict_i;
      nl_q  <= new_level_i;
      wr_q  <= writable_mount_i;
      now_q <= now_ticks_i;
    end
    set_q    <= set_d;
    res_st_q <= res_st_d;
    res_vd_q <= res_vd_d;
    res_lv_q <= res_lv_d;
    if (load_out) begin
      out_st_q <= res_st_q;
      out_vd_q <= res_vd_q;
      out_lv_q <= res_lv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign verdict_o   = out_vd_q;
  assign level_o     = out_lv_q;

endmodule
